>>> rtl/crc16_packet_deframe_check_assert.svh
// Assertion shorthands for the checker file.
`ifndef CRC16_PACKET_DEFRAME_CHECK_ASSERT_SVH
`define CRC16_PACKET_DEFRAME_CHECK_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CPDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CPDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cpdc_pkg.sv
package cpdc_pkg;

  localparam int unsigned CountW   = 34;
  localparam int unsigned HdrBytes = 10;
  localparam int unsigned CrcBytes = HdrBytes - 2;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcMsb  = 16'h8000;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SHORT_HDR = 2'd1,
    ST_SHORT_PAY = 2'd2,
    ST_BAD_CRC   = 2'd3
  } status_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  out_byte;
    logic [7:0]  pkt_type;
    logic [7:0]  sender;
    logic [15:0] seq_num;
    logic [31:0] payload_length;
    logic [1:0]  status;
    logic        out_last;
  } out_item_t;

  // Everything one request produces: an optional payload byte and an optional status.
  typedef struct packed {
    logic        has_pay;
    logic        has_stat;
    logic [7:0]  pay_byte;
    logic [7:0]  pkt_type;
    logic [7:0]  sender;
    logic [15:0] seq_num;
    logic [31:0] payload_length;
    status_e     status;
  } entry_t;

  // CRC-16/CCITT-FALSE update over one byte, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CrcMsb) != 16'h0000) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/crc16_packet_deframe_check.sv
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_stall_o   | in_i  (in_item_t: byte, last flag)
// out     | output    | out_valid_o / out_stall_i | out_o (out_item_t: one result)
//
// One byte is taken per cycle unless in_stall_o is high; header parse and the
// CRC byte update finish in the cycle of acceptance. A byte gives at most two
// results, queued in a two-entry result buffer; a byte that ends the buffer
// inside the payload gives a payload then a status result, so input stalls only
// then or under output stall. Results are registered in the head or skid entry.
// Asynchronous active-low reset clears counter and header fields, presets CRC.
module crc16_packet_deframe_check import cpdc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_o
);

  // Per-buffer parse state
  logic [CountW-1:0] count_q, count_d, count_inc;
  logic [15:0]       crc_q, crc_d, crc_upd;
  logic [7:0]        type_q, type_d, type_upd;
  logic [7:0]        sender_q, sender_d, sender_upd;
  logic [15:0]       seq_q, seq_d, seq_upd;
  logic [31:0]       len_q, len_d, len_upd;
  logic [15:0]       rxsum_q, rxsum_d, rxsum_upd;

  logic              accept, push, in_hdr, in_pay, hdr_short;
  logic [CountW-1:0] pay_off;
  logic [3:0]        hdr_pos;
  status_e           status;
  entry_t            entry;

  assign accept  = in_valid_i && !in_stall_o;
  assign in_hdr  = count_q < CountW'(HdrBytes);
  assign pay_off = count_q - CountW'(HdrBytes);
  // Bytes beyond the declared payload are trailing: no payload result, no CRC.
  assign in_pay  = !in_hdr && (pay_off < {2'b00, len_q});
  assign hdr_pos = count_q[3:0];

  // Capture header fields big-endian, advance the CRC.
  always_comb begin
    type_upd   = type_q;
    sender_upd = sender_q;
    seq_upd    = seq_q;
    len_upd    = len_q;
    rxsum_upd  = rxsum_q;
    if (in_hdr) begin
      case (hdr_pos)
        4'd0:                    type_upd   = in_i.in_byte;
        4'd1:                    sender_upd = in_i.in_byte;
        4'd2, 4'd3:              seq_upd    = {seq_q[7:0], in_i.in_byte};
        4'd4, 4'd5, 4'd6, 4'd7:  len_upd    = {len_q[23:0], in_i.in_byte};
        default:                 rxsum_upd  = {rxsum_q[7:0], in_i.in_byte};
      endcase
    end
    if ((count_q < CountW'(CrcBytes)) || in_pay) begin
      crc_upd = crc16_byte(crc_q, in_i.in_byte);
    end else begin
      crc_upd = crc_q;
    end
  end

  // Hold the counter at all-ones rather than wrap.
  assign count_inc = (count_q == '1) ? count_q : count_q + CountW'(1);

  // Status judged on the state after this byte.
  always_comb begin
    hdr_short = count_inc < CountW'(HdrBytes);
    if (hdr_short) begin
      status = ST_SHORT_HDR;
    end else if (count_inc < (CountW'(HdrBytes) + {2'b00, len_upd})) begin
      status = ST_SHORT_PAY;
    end else if (crc_upd != rxsum_upd) begin
      status = ST_BAD_CRC;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    entry                = '0;
    entry.has_pay        = in_pay;
    entry.has_stat       = in_i.in_last;
    entry.pay_byte       = in_i.in_byte;
    entry.status         = status;
    // A short header reports zeroed header fields.
    if (!(in_i.in_last && hdr_short)) begin
      entry.pkt_type       = type_upd;
      entry.sender         = sender_upd;
      entry.seq_num        = seq_upd;
      entry.payload_length = len_upd;
    end
  end

  assign push = accept && (in_pay || in_i.in_last);

  // Drop all state at the end of a buffer so the next byte starts afresh.
  always_comb begin
    count_d  = count_q;
    crc_d    = crc_q;
    type_d   = type_q;
    sender_d = sender_q;
    seq_d    = seq_q;
    len_d    = len_q;
    rxsum_d  = rxsum_q;
    if (accept) begin
      if (in_i.in_last) begin
        count_d  = '0;
        crc_d    = CrcInit;
        type_d   = '0;
        sender_d = '0;
        seq_d    = '0;
        len_d    = '0;
        rxsum_d  = '0;
      end else begin
        count_d  = count_inc;
        crc_d    = crc_upd;
        type_d   = type_upd;
        sender_d = sender_upd;
        seq_d    = seq_upd;
        len_d    = len_upd;
        rxsum_d  = rxsum_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      crc_q    <= CrcInit;
      type_q   <= '0;
      sender_q <= '0;
      seq_q    <= '0;
      len_q    <= '0;
      rxsum_q  <= '0;
    end else begin
      count_q  <= count_d;
      crc_q    <= crc_d;
      type_q   <= type_d;
      sender_q <= sender_d;
      seq_q    <= seq_d;
      len_q    <= len_d;
      rxsum_q  <= rxsum_d;
    end
  end

  // Result buffer: serialises payload and status, parts input from output.
  cpdc_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .entry_i     (entry),
    .full_o      (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

>>> rtl/cpdc_out_queue.sv
module cpdc_out_queue import cpdc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  entry_t    entry_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_o
);

  entry_t head_q, skid_q;
  logic   head_valid_q, skid_valid_q, phase_q;
  logic   head_valid_d, skid_valid_d, phase_d;
  logic   pop, entry_done, show_pay;

  // Payload byte goes first, status second.
  assign show_pay    = head_q.has_pay && !phase_q;
  assign out_valid_o = head_valid_q;
  assign full_o      = skid_valid_q;

  always_comb begin
    out_o                = '0;
    out_o.pkt_type       = head_q.pkt_type;
    out_o.sender         = head_q.sender;
    out_o.seq_num        = head_q.seq_num;
    out_o.payload_length = head_q.payload_length;
    if (show_pay) begin
      out_o.out_kind = KIND_PAYLOAD;
      out_o.out_byte = head_q.pay_byte;
      out_o.status   = ST_OK;
      out_o.out_last = !head_q.has_stat;
    end else begin
      out_o.out_kind = KIND_STATUS;
      out_o.out_byte = 8'h00;
      out_o.status   = head_q.status;
      out_o.out_last = 1'b1;
    end
  end

  assign pop        = head_valid_q && !out_stall_i;
  assign entry_done = pop && !(show_pay && head_q.has_stat);

  always_comb begin
    head_valid_d = head_valid_q;
    skid_valid_d = skid_valid_q;
    phase_d      = phase_q;
    if (pop) begin
      phase_d = !entry_done;
    end
    if (entry_done || !head_valid_q) begin
      if (skid_valid_q) begin
        head_valid_d = 1'b1;
        skid_valid_d = push_i;
      end else begin
        head_valid_d = push_i;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
      phase_q      <= 1'b0;
    end else begin
      head_valid_q <= head_valid_d;
      skid_valid_q <= skid_valid_d;
      phase_q      <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (entry_done || !head_valid_q) begin
      head_q <= skid_valid_q ? skid_q : entry_i;
      skid_q <= entry_i;
    end else if (push_i) begin
      skid_q <= entry_i;
    end
  end

endmodule

>>> rtl/cpdc_checker.sv
`include "crc16_packet_deframe_check_assert.svh"

module cpdc_checker import cpdc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_o
);

  logic out_take;
  assign out_take = out_valid_o && !out_stall_i;

  `CPDC_ASSERT_NOW(a_status_is_last, out_valid_o && out_o.out_kind == KIND_STATUS, out_o.out_last == 1'b1, "status result without out_last")
  `CPDC_ASSERT_NEXT(a_status_follows, out_take && out_o.out_kind == KIND_PAYLOAD && !out_o.out_last, out_valid_o && out_o.out_kind == KIND_STATUS, "status result missing after payload")
  `CPDC_ASSERT_NOW(a_short_hdr_zero, out_valid_o && out_o.out_kind == KIND_STATUS && out_o.status == ST_SHORT_HDR, out_o.pkt_type == 8'h00 && out_o.sender == 8'h00 && out_o.seq_num == 16'h0000 && out_o.payload_length == 32'h0, "short header reports header fields")
  `CPDC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_o), "stalled result changed")

endmodule

bind crc16_packet_deframe_check cpdc_checker u_cpdc_checker (.*);

>>> verif/deframe_sb_pkg.sv
package deframe_sb_pkg;
  import cpdc_pkg::*;

  class deframe_scoreboard;
    // Shadow of the deframer state.
    logic [CountW-1:0] seen_cnt;
    logic [15:0]       run_crc;
    logic [7:0]        hdr_type;
    logic [7:0]        hdr_sender;
    logic [15:0]       hdr_seq;
    logic [31:0]       hdr_len;
    logic [15:0]       hdr_crc;

    out_item_t   due_results[$];
    int unsigned fault_cnt;
    int unsigned checked_cnt;
    int unsigned byte_cnt;
    int unsigned pay_cnt;
    int unsigned status_cnt[4];

    function new();
      fault_cnt   = 0;
      checked_cnt = 0;
      byte_cnt    = 0;
      pay_cnt     = 0;
      foreach (status_cnt[k]) status_cnt[k] = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      seen_cnt   = '0;
      run_crc    = CrcInit;
      hdr_type   = '0;
      hdr_sender = '0;
      hdr_seq    = '0;
      hdr_len    = '0;
      hdr_crc    = '0;
    endfunction

    // Shift one byte through the CRC register, one bit at a time, MSB first.
    static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] data);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int k = 7; k >= 0; k--) begin
        fb = c[15] ^ data[k];
        c  = {c[14:0], 1'b0};
        if (fb) c = c ^ CrcPoly;
      end
      return c;
    endfunction

    function out_item_t make_result(kind_e kind, logic [7:0] data, bit with_hdr,
                                    status_e st, logic last);
      out_item_t r;
      r.out_kind       = kind;
      r.out_byte       = data;
      r.pkt_type       = with_hdr ? hdr_type : 8'h00;
      r.sender         = with_hdr ? hdr_sender : 8'h00;
      r.seq_num        = with_hdr ? hdr_seq : 16'h0000;
      r.payload_length = with_hdr ? hdr_len : 32'h0;
      r.status         = st;
      r.out_last       = last;
      return r;
    endfunction

    // Note one accepted request and queue the results it must cause.
    function void take_byte(in_item_t req);
      logic [CountW-1:0] pos;
      logic [7:0]        b;
      status_e           st;
      pos = seen_cnt;
      b   = req.in_byte;
      byte_cnt++;
      if (pos < HdrBytes) begin
        case (pos)
          0:          hdr_type   = b;
          1:          hdr_sender = b;
          2, 3:       hdr_seq    = {hdr_seq[7:0], b};
          4, 5, 6, 7: hdr_len    = {hdr_len[23:0], b};
          default:    hdr_crc    = {hdr_crc[7:0], b};
        endcase
        if (pos < CrcBytes) run_crc = crc_step(run_crc, b);
      end else if (pos - HdrBytes < {2'b00, hdr_len}) begin
        run_crc = crc_step(run_crc, b);
        due_results.insert(due_results.size(),
                           make_result(KIND_PAYLOAD, b, 1'b1, ST_OK, !req.in_last));
        pay_cnt++;
      end
      if (seen_cnt != {CountW{1'b1}}) seen_cnt++;
      if (req.in_last) begin
        if (seen_cnt < HdrBytes)
          st = ST_SHORT_HDR;
        else if ({1'b0, seen_cnt} < 35'(HdrBytes) + {3'b000, hdr_len})
          st = ST_SHORT_PAY;
        else if (run_crc != hdr_crc)
          st = ST_BAD_CRC;
        else
          st = ST_OK;
        due_results.insert(due_results.size(),
                           make_result(KIND_STATUS, 8'h00, st != ST_SHORT_HDR, st, 1'b1));
        status_cnt[st]++;
        clear_frame();
      end
    endfunction

    task report(string what);
      fault_cnt++;
      if (fault_cnt <= 30) $display("[%0t] MISMATCH %s", $time, what);
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("result %0d, %s: got %0h, expected %0h", checked_cnt, name, got, want));
    endtask

    // Compare one accepted result with the oldest expectation.
    task match_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", checked_cnt));
        checked_cnt++;
        return;
      end
      want = due_results.pop_front();
      check_field("out_kind", got.out_kind, want.out_kind);
      check_field("out_byte", got.out_byte, want.out_byte);
      check_field("pkt_type", got.pkt_type, want.pkt_type);
      check_field("sender", got.sender, want.sender);
      check_field("seq_num", got.seq_num, want.seq_num);
      check_field("payload_length", got.payload_length, want.payload_length);
      check_field("status", got.status, want.status);
      check_field("out_last", got.out_last, want.out_last);
      checked_cnt++;
    endtask
  endclass

endpackage

>>> verif/tb_crc16_packet_deframe_check.sv
module tb_crc16_packet_deframe_check;
  timeunit 1ns;
  timeprecision 1ps;

  import cpdc_pkg::*;
  import deframe_sb_pkg::*;

  localparam int unsigned NumReqs    = 1900;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned CycleLimit = 1_000_000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_o;

  deframe_scoreboard sb = new();

  int unsigned cycle_cnt = 0;
  int unsigned sent_cnt  = 0;
  int unsigned frame_cnt = 0;
  int unsigned gap_mode  = 0;   // sender idling: 0 none, 1 light, 2 heavy
  bit          held_off  = 0;

  crc16_packet_deframe_check dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // Watch both channels. Every signal read here changes only after the edge, so
  // the values seen are the ones the block sampled.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.take_byte(in_i);
      if (out_valid_o && !out_stall_i) sb.match_result(out_o);
    end
  end

  // Pick the idle time before the next request: mostly short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (gap_mode)
      0:       return 0;
      1:       return (roll < 75) ? 0 : (roll < 95) ? $urandom_range(1, 3)
                                                    : $urandom_range(10, 40);
      default: return (roll < 40) ? 0 : (roll < 85) ? $urandom_range(1, 4)
                                                    : $urandom_range(5, 25);
    endcase
  endfunction

  // Offer one request and hold it until the block takes it. Valid is only
  // lowered when a gap really follows, so back-to-back requests keep it high.
  task automatic send_req(input in_item_t req);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_cnt++;
  endtask

  // Build one receive buffer: header, pay_sent payload bytes, trail trailing
  // bytes, then cut it to `cut` bytes when cut is non-zero. Corrupt the
  // checksum on request. Flag the final byte as the end of the buffer.
  task automatic send_frame(input logic [7:0] ptype, input logic [7:0] src,
                            input logic [15:0] seq, input logic [31:0] plen,
                            input int unsigned pay_sent, input int unsigned trail,
                            input bit corrupt, input int unsigned cut);
    logic [7:0]  frame_q[$];
    logic [7:0]  pay_q[$];
    logic [15:0] crc;
    in_item_t    req;
    int unsigned n;
    frame_q = {ptype, src, seq[15:8], seq[7:0],
               plen[31:24], plen[23:16], plen[15:8], plen[7:0]};
    crc = CrcInit;
    foreach (frame_q[k]) crc = deframe_scoreboard::crc_step(crc, frame_q[k]);
    for (int k = 0; k < pay_sent; k++) begin
      pay_q.insert(pay_q.size(), 8'($urandom));
      crc = deframe_scoreboard::crc_step(crc, pay_q[k]);
    end
    if (corrupt) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    frame_q.insert(frame_q.size(), crc[15:8]);
    frame_q.insert(frame_q.size(), crc[7:0]);
    foreach (pay_q[k]) frame_q.insert(frame_q.size(), pay_q[k]);
    repeat (trail) frame_q.insert(frame_q.size(), 8'($urandom));
    n = (cut != 0 && cut < frame_q.size()) ? cut : frame_q.size();
    for (int k = 0; k < n; k++) begin
      req.in_byte = frame_q[k];
      req.in_last = (k == n - 1);
      send_req(req);
    end
    frame_cnt++;
  endtask

  // Receiver: stall at random in stretches, and once hold off for a long run
  // while the sender keeps offering, so the result buffer fills and the block
  // stalls its input.
  initial begin
    int unsigned stall_left;
    int unsigned stall_mode;
    int unsigned hold_left;
    int unsigned roll;
    stall_left = 0;
    stall_mode = 0;
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (!held_off && sb.checked_cnt >= 150) begin
        out_stall_i <= 1'b1;
        hold_left = HoldCycles;
        while (hold_left != 0) begin
          @(posedge clk_i);
          hold_left--;
        end
        held_off = 1;
      end
      if (cycle_cnt % 256 == 0) stall_mode = $urandom_range(0, 2);
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        roll = $urandom_range(0, 99);
        if (stall_mode == 0 || (stall_mode == 1 && roll < 85) ||
            (stall_mode == 2 && roll < 50)) begin
          out_stall_i <= 1'b0;
        end else begin
          out_stall_i <= 1'b1;
          if (stall_mode == 1)
            stall_left = (roll < 97) ? $urandom_range(0, 2) : $urandom_range(7, 39);
          else
            stall_left = (roll < 90) ? $urandom_range(0, 3) : $urandom_range(4, 29);
        end
      end
    end
  end

  // Give up once the cycle budget is spent.
  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("timeout after %0d cycles, %0d results still due",
             cycle_cnt, sb.due_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus.
  initial begin
    int unsigned pick;
    logic [31:0] plen;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_i       <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a one-byte buffer (short header), a packet whose final byte is
    // its only payload byte (payload then status, ok), and an empty-payload
    // packet with a bad checksum and trailing bytes that must be ignored.
    send_frame(8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 0, 0, 0, 1);
    send_frame(8'h00, 8'hFF, 16'hFFFF, 32'd1, 1, 0, 0, 0);
    send_frame(8'hFF, 8'h00, 16'h0000, 32'd0, 0, 2, 1, 0);

    // Random: mostly well-formed packets with random content, the rest broken
    // buffers and noise.
    while (sent_cnt < NumReqs) begin
      gap_mode = $urandom_range(0, 2);
      pick = $urandom_range(0, 99);
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
      if (pick < 40) begin
        send_frame(8'($urandom), 8'($urandom), 16'($urandom), plen, plen, 0, 0, 0);
      end else if (pick < 55) begin
        send_frame(8'($urandom), 8'($urandom), 16'($urandom), plen, plen,
                   $urandom_range(1, 5), 0, 0);
      end else if (pick < 67) begin
        send_frame(8'($urandom), 8'($urandom), 16'($urandom), plen, plen,
                   $urandom_range(0, 2), 1, 0);
      end else if (pick < 77) begin
        if (plen == 0) plen = 1;
        send_frame(8'($urandom), 8'($urandom), 16'($urandom), plen,
                   $urandom_range(0, plen - 1), 0, 0, 0);
      end else if (pick < 85) begin
        send_frame(8'($urandom), 8'($urandom), 16'($urandom), plen, plen, 0, 0,
                   $urandom_range(1, HdrBytes - 1));
      end else begin
        send_frame(8'($urandom), 8'($urandom), 16'($urandom), 32'($urandom),
                   $urandom_range(0, 12), $urandom_range(0, 3), 1'($urandom),
                   $urandom_range(1, 30));
      end
    end
    in_valid_i <= 1'b0;

    // Drain: wait for every due result, then wait on to catch strays.
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("sent %0d requests in %0d buffers; %0d payload results, %0d results checked",
             sb.byte_cnt, frame_cnt, sb.pay_cnt, sb.checked_cnt);
    $display("status seen: ok %0d, short header %0d, short payload %0d, bad checksum %0d",
             sb.status_cnt[ST_OK], sb.status_cnt[ST_SHORT_HDR],
             sb.status_cnt[ST_SHORT_PAY], sb.status_cnt[ST_BAD_CRC]);
    if (sb.fault_cnt == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
